// ----- hdl/mbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and the color microprogram for the escape-time pixel block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 10;
  localparam int CNT_W     = 16;
  localparam int CLR_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int ORG_W     = 32;
  localparam int STEP_W    = 31;
  localparam int PIX_W     = STEP_W + COL_W;     // index times step
  localparam int COORD_W   = 44;                 // z and c, signed
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQP_W     = PROD_W - FRAC_BITS; // shifted product
  localparam int SQ_W      = 32;                 // capped square
  localparam int SUM_W     = SQ_W + 1;
  localparam int XY_W      = SQP_W + 1;          // signed cross product
  localparam int T_W       = 80;                 // color numerator
  localparam int DM_W      = 64;                 // limit^4
  localparam int CMUL_W    = MUL_W + CNT_W;
  localparam int PC_W      = 5;
  localparam int SUB_W     = 4;
  localparam logic [SUB_W-1:0] MUL_LAST = SUB_W'(2);
  localparam logic [SUB_W-1:0] DIV_LAST = SUB_W'(9);

  localparam logic [COORD_W-1:0] Q_ONE     = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] Q_TWO     = COORD_W'(2) << FRAC_BITS;
  localparam logic [COORD_W-1:0] Q_QUARTER = Q_ONE >> 2;
  localparam logic [COORD_W-1:0] SQ_LIM    = COORD_W'(3) << FRAC_BITS;
  localparam logic [SQ_W-1:0]    SQ_CAP    = SQ_W'(8) << FRAC_BITS;
  localparam logic [SUM_W-1:0]   ESC_LIM   = SUM_W'(4) << FRAC_BITS;
  localparam logic [SUM_W-1:0]   Q_SIXTEENTH = SUM_W'(1) << (FRAC_BITS - 4);

  localparam logic [ORG_W-1:0]  RST_X_ORIGIN = 32'hE000_0000;
  localparam logic [ORG_W-1:0]  RST_Y_ORIGIN = 32'hF2CC_CCCD;
  localparam logic [STEP_W-1:0] RST_X_STEP   = 31'd10066330;
  localparam logic [STEP_W-1:0] RST_Y_STEP   = 31'd20132659;
  localparam logic [CNT_W-1:0]  RST_ITER_LIM = 16'd100;

  localparam logic [CNT_W-1:0] K_RED   = 16'd2295;
  localparam logic [CNT_W-1:0] K_GREEN = 16'd3825;
  localparam logic [CNT_W-1:0] K_BLUE  = 16'd4335;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_X_STEP   = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_ITER_LIM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic             inside_res;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_PREP, ST_SQ, ST_LHS, ST_BULB,
    ST_ITER, ST_FIN, ST_COLOR, ST_WAITC, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } clr_ctl_t;

  typedef struct packed {
    logic done;
  } clr_sts_t;

  typedef enum logic [2:0] {OP_LOAD, OP_MUL, OP_SAVE, OP_DIV, OP_END} op_kind_t;
  typedef enum logic [2:0] {OPD_M, OPD_N, OPD_D, OPD_KR, OPD_KG, OPD_KB} opd_t;
  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} ch_t;

  typedef struct packed {
    op_kind_t kind;
    opd_t     opd;
    ch_t      ch;
    logic     dbl;
  } col_op_t;

  // t = load, t *= operand; divide t by m^4 (doubled for blue)
  function automatic col_op_t col_op(input logic [PC_W-1:0] pc);
    col_op_t o;
    o = '{kind: OP_END, opd: OPD_M, ch: CH_RED, dbl: 1'b0};
    unique case (pc)
      5'd0:  o = '{OP_LOAD, OPD_M,  CH_RED,   1'b0};
      5'd1:  o = '{OP_MUL,  OPD_M,  CH_RED,   1'b0};
      5'd2:  o = '{OP_MUL,  OPD_M,  CH_RED,   1'b0};
      5'd3:  o = '{OP_MUL,  OPD_M,  CH_RED,   1'b0};
      5'd4:  o = '{OP_SAVE, OPD_M,  CH_RED,   1'b0};
      5'd5:  o = '{OP_LOAD, OPD_D,  CH_RED,   1'b0};
      5'd6:  o = '{OP_MUL,  OPD_KR, CH_RED,   1'b0};
      5'd7:  o = '{OP_MUL,  OPD_N,  CH_RED,   1'b0};
      5'd8:  o = '{OP_MUL,  OPD_N,  CH_RED,   1'b0};
      5'd9:  o = '{OP_MUL,  OPD_N,  CH_RED,   1'b0};
      5'd10: o = '{OP_DIV,  OPD_M,  CH_RED,   1'b0};
      5'd11: o = '{OP_LOAD, OPD_D,  CH_GREEN, 1'b0};
      5'd12: o = '{OP_MUL,  OPD_KG, CH_GREEN, 1'b0};
      5'd13: o = '{OP_MUL,  OPD_D,  CH_GREEN, 1'b0};
      5'd14: o = '{OP_MUL,  OPD_N,  CH_GREEN, 1'b0};
      5'd15: o = '{OP_MUL,  OPD_N,  CH_GREEN, 1'b0};
      5'd16: o = '{OP_DIV,  OPD_M,  CH_GREEN, 1'b0};
      5'd17: o = '{OP_LOAD, OPD_D,  CH_BLUE,  1'b0};
      5'd18: o = '{OP_MUL,  OPD_KB, CH_BLUE,  1'b0};
      5'd19: o = '{OP_MUL,  OPD_D,  CH_BLUE,  1'b0};
      5'd20: o = '{OP_MUL,  OPD_D,  CH_BLUE,  1'b0};
      5'd21: o = '{OP_MUL,  OPD_N,  CH_BLUE,  1'b0};
      5'd22: o = '{OP_DIV,  OPD_M,  CH_BLUE,  1'b1};
      default: o = '{OP_END, OPD_M, CH_RED,   1'b0};
    endcase
    return o;
  endfunction

endpackage

// ----- hdl/mbe_csq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_csq
// Complex square unit: capped x^2, y^2 and signed x*y in fixed point.
// ----------------------------------------------------------------------------
module mbe_csq (
  input  logic signed [mbe_pkg::COORD_W-1:0] x,
  input  logic signed [mbe_pkg::COORD_W-1:0] y,
  output logic [mbe_pkg::SQ_W-1:0]           sq_x,
  output logic [mbe_pkg::SQ_W-1:0]           sq_y,
  output logic signed [mbe_pkg::XY_W-1:0]    xy
);
  import mbe_pkg::*;

  logic [COORD_W-1:0] mx, my;
  logic [PROD_W-1:0]  pxx, pyy, pxy;
  logic [SQP_W-1:0]   sxx, syy, sxy;

  assign mx  = x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
  assign my  = y[COORD_W-1] ? COORD_W'(-y) : COORD_W'(y);
  assign pxx = PROD_W'(mx[MUL_W-1:0]) * PROD_W'(mx[MUL_W-1:0]);
  assign pyy = PROD_W'(my[MUL_W-1:0]) * PROD_W'(my[MUL_W-1:0]);
  assign pxy = PROD_W'(mx[MUL_W-1:0]) * PROD_W'(my[MUL_W-1:0]);
  assign sxx = SQP_W'(pxx >> FRAC_BITS);
  assign syy = SQP_W'(pyy >> FRAC_BITS);
  assign sxy = SQP_W'(pxy >> FRAC_BITS);

  // magnitude of 3.0 or more always squares past the 8.0 cap
  assign sq_x = (mx >= SQ_LIM || sxx > SQP_W'(SQ_CAP)) ? SQ_CAP : sxx[SQ_W-1:0];
  assign sq_y = (my >= SQ_LIM || syy > SQP_W'(SQ_CAP)) ? SQ_CAP : syy[SQ_W-1:0];
  assign xy   = (x[COORD_W-1] ^ y[COORD_W-1]) ? -$signed({1'b0, sxy}) : $signed({1'b0, sxy});

endmodule

// ----- hdl/mbe_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_color
// Microcoded color unit: products on one 32x16 multiplier, then a restoring
// divide by the limit^4 (doubled for blue), clamped to 255.
// ----------------------------------------------------------------------------
module mbe_color (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbe_pkg::clr_ctl_t           ctl,
  input  logic [mbe_pkg::CNT_W-1:0]   n,
  input  logic [mbe_pkg::CNT_W-1:0]   m,
  output mbe_pkg::clr_sts_t           sts,
  output logic [mbe_pkg::CLR_W-1:0]   red,
  output logic [mbe_pkg::CLR_W-1:0]   green,
  output logic [mbe_pkg::CLR_W-1:0]   blue
);
  import mbe_pkg::*;

  logic              running_r;
  logic [PC_W-1:0]   pc_r;
  logic [SUB_W-1:0]  sub_r;
  logic [CNT_W-1:0]  diff_r;
  logic [T_W-1:0]    t_r, rem_r, dv_r;
  logic [CMUL_W-1:0] prod_r, lo_r;
  logic [DM_W-1:0]   dm_r;
  logic [CLR_W-1:0]  q_r, red_r, green_r, blue_r;
  col_op_t           op;
  logic [CNT_W-1:0]  opd_val;
  logic [MUL_W-1:0]  mul_a;
  logic              ge, op_last;
  logic [CLR_W-1:0]  q_fin;

  assign op = col_op(pc_r);

  always_comb begin
    unique case (op.opd)
      OPD_M:   opd_val = m;
      OPD_N:   opd_val = n;
      OPD_D:   opd_val = diff_r;
      OPD_KR:  opd_val = K_RED;
      OPD_KG:  opd_val = K_GREEN;
      OPD_KB:  opd_val = K_BLUE;
      default: opd_val = m;
    endcase
  end

  assign mul_a = sub_r[0] ? t_r[2*MUL_W-1:MUL_W] : t_r[MUL_W-1:0];
  assign ge    = rem_r >= dv_r;
  assign q_fin = (sub_r == SUB_W'(1)) ? {CLR_W{1'b1}} : {q_r[CLR_W-2:0], ge};

  always_comb begin
    unique case (op.kind)
      OP_MUL:  op_last = (sub_r == MUL_LAST);
      OP_DIV:  op_last = (sub_r == SUB_W'(1) && ge) || sub_r == DIV_LAST;
      default: op_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pc_r      <= '0;
      sub_r     <= '0;
    end else if (!running_r) begin
      if (ctl.start) begin
        running_r <= 1'b1;
        pc_r      <= '0;
        sub_r     <= '0;
      end
    end else if (op.kind == OP_END) begin
      running_r <= 1'b0;
    end else if (op_last) begin
      pc_r  <= pc_r + PC_W'(1);
      sub_r <= '0;
    end else begin
      sub_r <= sub_r + SUB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= CMUL_W'(mul_a) * CMUL_W'(opd_val);
    if (!running_r && ctl.start) begin
      diff_r <= m - n;
    end
    if (running_r) begin
      unique case (op.kind)
        OP_LOAD: t_r <= T_W'(opd_val);
        OP_SAVE: dm_r <= t_r[DM_W-1:0];
        OP_MUL: begin
          if (sub_r == SUB_W'(1)) lo_r <= prod_r;
          if (sub_r == MUL_LAST) t_r <= T_W'(lo_r) + (T_W'(prod_r) << MUL_W);
        end
        OP_DIV: begin
          if (sub_r == '0) begin
            rem_r <= t_r;
            dv_r  <= T_W'(dm_r) << (op.dbl ? CLR_W + 1 : CLR_W);
          end else begin
            if (sub_r != SUB_W'(1) && ge) rem_r <= rem_r - dv_r;
            dv_r <= dv_r >> 1;
            q_r  <= {q_r[CLR_W-2:0], ge};
            if (op_last) begin
              unique case (op.ch)
                CH_RED:   red_r   <= q_fin;
                CH_GREEN: green_r <= q_fin;
                CH_BLUE:  blue_r  <= q_fin;
                default:  red_r   <= q_fin;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.done = running_r && op.kind == OP_END;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

endmodule

// ----- hdl/mandelbrot_escape_time_color_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_color_top
// Escape-time pixel engine with polynomial RGB coloring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one pixel (column, row).
//   A transfer happens when in_valid is high and in_stall low. in_stall stays
//   high from the cycle after a transfer until the pixel's result is loaded
//   into the output register; one pixel is in work at a time.
//   Setup and the cardioid/bulb check come first. Each iteration of
//   z = z*z + c runs on the complex square unit. An escaped pixel then
//   goes through the color unit (fifteen wide products on its 32x16
//   multiplier and three divides); an inside pixel skips it.
//   Results sit in an output register (out_valid/out_stall/out_data); a new
//   pixel is taken while a result waits, and a stalled result holds.
//   Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken
//   and must only be issued while no pixel is in work. Synchronous reset
//   returns the registers to their defaults and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_color_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mbe_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mbe_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import mbe_pkg::*;

  state_t state_r, state_nxt;

  logic [ORG_W-1:0]  x_origin_r, y_origin_r;
  logic [STEP_W-1:0] x_step_r, y_step_r;
  logic [CNT_W-1:0]  iter_lim_r, n_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, a_r, b_r, q_r, qa_r, x_r, y_r;
  logic [SQ_W-1:0]   yy_r;

  logic [PIX_W-1:0]  px_x, px_y;
  logic signed [COORD_W-1:0] x0_nxt, y0_nxt, x_nxt, y_nxt, q_nxt, cs_x, cs_y, xy_ext;
  logic [COORD_W-1:0] mag_x0, mag_y0;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic signed [XY_W-1:0] xy;
  logic [SUM_W-1:0]  sum_sq;
  logic              far, lhs_in, bulb_in, iter_stop, blank, in_xfer, out_load;

  logic              out_valid_r;
  out_item_t         out_data_r, out_nxt;
  clr_ctl_t          clr_ctl;
  clr_sts_t          clr_sts;
  logic [CLR_W-1:0]  clr_r, clr_g, clr_b;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= RST_X_ORIGIN;
      y_origin_r <= RST_Y_ORIGIN;
      x_step_r   <= RST_X_STEP;
      y_step_r   <= RST_Y_STEP;
      iter_lim_r <= RST_ITER_LIM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin_r <= cfg_data[ORG_W-1:0];
        CFG_Y_ORIGIN: y_origin_r <= cfg_data[ORG_W-1:0];
        CFG_X_STEP:   x_step_r   <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:   y_step_r   <= cfg_data[STEP_W-1:0];
        CFG_ITER_LIM: iter_lim_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // complex square unit, shared by the region test and the iteration
  always_comb begin
    unique case (state_r)
      ST_SQ:   begin cs_x = a_r; cs_y = y0_r; end
      ST_LHS:  begin cs_x = q_r; cs_y = qa_r; end
      ST_BULB: begin cs_x = b_r; cs_y = '0;   end
      default: begin cs_x = x_r; cs_y = y_r;  end
    endcase
  end

  mbe_csq u_csq (
    .x    (cs_x),
    .y    (cs_y),
    .sq_x (sq_x),
    .sq_y (sq_y),
    .xy   (xy)
  );

  assign px_x   = PIX_W'(col_r) * PIX_W'(x_step_r);
  assign px_y   = PIX_W'(row_r) * PIX_W'(y_step_r);
  assign x0_nxt = $signed({{(COORD_W-ORG_W){x_origin_r[ORG_W-1]}}, x_origin_r})
                + $signed({{(COORD_W-PIX_W){1'b0}}, px_x});
  assign y0_nxt = $signed({{(COORD_W-ORG_W){y_origin_r[ORG_W-1]}}, y_origin_r})
                + $signed({{(COORD_W-PIX_W){1'b0}}, px_y});

  assign mag_x0 = x0_r[COORD_W-1] ? COORD_W'(-x0_r) : COORD_W'(x0_r);
  assign mag_y0 = y0_r[COORD_W-1] ? COORD_W'(-y0_r) : COORD_W'(y0_r);
  assign far    = mag_x0 >= Q_TWO || mag_y0 >= Q_TWO;

  assign sum_sq  = {1'b0, sq_x} + {1'b0, sq_y};
  assign q_nxt   = $signed({{(COORD_W-SUM_W){1'b0}}, sum_sq});
  assign lhs_in  = xy < $signed({{(XY_W-SQ_W){1'b0}}, yy_r >> 2});
  assign bulb_in = ({1'b0, sq_x} + {1'b0, yy_r}) < Q_SIXTEENTH;

  assign iter_stop = sum_sq > ESC_LIM || n_r >= iter_lim_r;
  assign xy_ext    = $signed({{(COORD_W-XY_W){xy[XY_W-1]}}, xy});
  assign x_nxt     = $signed({{(COORD_W-SQ_W){1'b0}}, sq_x})
                   - $signed({{(COORD_W-SQ_W){1'b0}}, sq_y}) + x0_r;
  assign y_nxt     = (xy_ext <<< 1) + y0_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = far ? ST_ITER : ST_SQ;
      ST_SQ:    state_nxt = ST_LHS;
      ST_LHS:   state_nxt = lhs_in ? ST_FIN : ST_BULB;
      ST_BULB:  state_nxt = bulb_in ? ST_FIN : ST_ITER;
      ST_ITER:  if (iter_stop) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = (n_r == iter_lim_r) ? ST_DONE : ST_COLOR;
      ST_COLOR: state_nxt = ST_WAITC;
      ST_WAITC: if (clr_sts.done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    clr_ctl.start = state_r == ST_COLOR;
    out_load      = state_r == ST_DONE && (!out_valid_r || !out_stall);
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          col_r <= in_data.column;
          row_r <= in_data.row;
        end
      end
      ST_SETUP: begin
        x0_r <= x0_nxt;
        y0_r <= y0_nxt;
      end
      ST_PREP: begin
        a_r <= x0_r - Q_QUARTER;
        b_r <= x0_r + Q_ONE;
        x_r <= '0;
        y_r <= '0;
        n_r <= '0;
      end
      ST_SQ: begin
        yy_r <= sq_y;
        q_r  <= q_nxt;
        qa_r <= q_nxt + a_r;
      end
      ST_LHS: if (lhs_in) n_r <= iter_lim_r;
      ST_BULB: if (bulb_in) n_r <= iter_lim_r;
      ST_ITER: begin
        if (!iter_stop) begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          n_r <= n_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  mbe_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (clr_ctl),
    .n     (n_r),
    .m     (iter_lim_r),
    .sts   (clr_sts),
    .red   (clr_r),
    .green (clr_g),
    .blue  (clr_b)
  );

  // output register
  assign blank = n_r == iter_lim_r;
  always_comb begin
    out_nxt.iter_count = n_r;
    out_nxt.inside_res = blank;
    out_nxt.red        = blank ? '0 : clr_r;
    out_nxt.green      = blank ? '0 : clr_g;
    out_nxt.blue       = blank ? '0 : clr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (out_load)               out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/mbe_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_chk
// Port-level checks for the escape-time pixel block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mbe_pkg::out_item_t  out_data
);
  import mbe_pkg::*;

  // one pixel in work: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a pixel is in work");

  // inside pixels are blank
  a_inside_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.inside_res) |->
      (out_data.red == '0 && out_data.green == '0 && out_data.blue == '0))
    else $error("inside pixel carries color");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind mandelbrot_escape_time_color_top mbe_chk u_chk (.*);

// ----- verif/mandelbrot_escape_time_color_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_color_top_tb
// Drives pixels through the escape-time engine under random idle patterns
// on both channels and a range of view and limit settings. A directed table
// comes first, then random views. Every result is checked field by field
// in order against typed values or bit-exact fixed-point pixel predictions.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_color_top_tb;
  import mbe_pkg::*;

  localparam logic [63:0] SQ_SAT   = 64'd8 << 28;
  localparam logic [63:0] WIDE_SAT = 64'd1 << 60;
  localparam logic [63:0] ESC_Q    = 64'd4 << 28;
  localparam longint      ONE_Q    = longint'(1) << 28;

  typedef struct {
    bit         is_cfg;
    cfg_reg_t   idx;
    logic [31:0] val;
    in_item_t   px;
    bit         typed;
    out_item_t  want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // view and limit as currently programmed
  longint      view_x, view_y;
  logic [63:0] step_x, step_y, iter_lim;

  out_item_t   pending_px[$];
  dir_row_t    dir_tab[$];
  int          mismatches = 0;
  int          in_idle = 0, out_idle = 0;

  always #5 clk = ~clk;

  mandelbrot_escape_time_color_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:92] != '0) return cap;
    r = p[91:28];
    return r > cap ? cap : r;
  endfunction

  function automatic longint qmul_s(longint a, longint b);
    logic [63:0] m;
    m = qmul(mag(a), mag(b), WIDE_SAT);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] qsq(longint a);
    return qmul(mag(a), mag(a), SQ_SAT);
  endfunction

  function automatic bit in_cardioid_or_bulb(longint x0, longint y0);
    longint a, q, lhs, rhs, b;
    logic [63:0] yy;
    if (mag(x0) >= (64'd2 << 28) || mag(y0) >= (64'd2 << 28)) return 1'b0;
    yy  = qsq(y0);
    a   = x0 - (ONE_Q >>> 2);
    q   = longint'(qsq(a)) + longint'(yy);
    lhs = qmul_s(q, q + a);
    rhs = longint'(yy >> 2);
    if (lhs < rhs) return 1'b1;
    b = x0 + ONE_Q;
    return (longint'(qsq(b)) + longint'(yy)) < (ONE_Q >>> 4);
  endfunction

  function automatic logic [7:0] shade(logic [63:0] na, logic [63:0] nb,
                                       logic [63:0] dscale, logic [63:0] m2);
    logic [127:0] num, den, r;
    num = {64'd0, na} * {64'd0, nb};
    den = {64'd0, dscale * m2} * {64'd0, m2};
    r = num / den;
    return r > 255 ? 8'd255 : r[7:0];
  endfunction

  function automatic out_item_t pixel_color(in_item_t p);
    out_item_t o;
    longint x0, y0, x, y;
    logic [63:0] n, m, d, m2, x2, y2;
    x0 = view_x + longint'(64'(p.column) * step_x);
    y0 = view_y + longint'(64'(p.row) * step_y);
    m = iter_lim;
    n = 0;
    o = '0;
    if (in_cardioid_or_bulb(x0, y0)) begin
      n = m;
    end else begin
      x = 0; y = 0; x2 = 0; y2 = 0;
      while (x2 + y2 <= ESC_Q && n < m) begin
        y = qmul_s(x, y) * 2 + y0;
        x = longint'(x2) - longint'(y2) + x0;
        x2 = qsq(x);
        y2 = qsq(y);
        n++;
      end
    end
    if (n != m) begin
      d = m - n;
      m2 = m * m;
      o.red   = shade(64'd2295 * d, n * n * n, 64'd1, m2);
      o.green = shade(64'd3825 * d * d, n * n, 64'd1, m2);
      o.blue  = shade(64'd4335 * d * d * d, n, 64'd2, m2);
    end
    o.iter_count = n[15:0];
    o.inside_res = (n == m);
    return o;
  endfunction

  // called at a falling edge; returns at a falling edge with cfg_valid low
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_ORIGIN: view_x = longint'($signed(val));
      CFG_Y_ORIGIN: view_y = longint'($signed(val));
      CFG_X_STEP:   step_x = {33'd0, val[30:0]};
      CFG_Y_STEP:   step_y = {33'd0, val[30:0]};
      CFG_ITER_LIM: iter_lim = {48'd0, val[15:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge with in_valid low
  task automatic send_pixel(in_item_t p, bit typed, out_item_t want);
    while ($urandom_range(0, 99) < in_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    pending_px.push_back(typed ? want : pixel_color(p));
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic add_cfg(cfg_reg_t idx, logic [31:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.px     = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    dir_tab.push_back(r);
  endtask

  task automatic add_px(int c, int rw, bit typed, out_item_t want);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_X_ORIGIN;
    r.val    = '0;
    r.px     = '{column: COL_W'(c), row: ROW_W'(rw)};
    r.typed  = typed;
    r.want   = want;
    dir_tab.push_back(r);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < out_idle);

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_data);
      end else begin
        want = pending_px.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_item_t  none, esc1, full100, zero_lim, one_lim;
    in_item_t   p;
    int         sent, batch, long_run;
    view_x = -536870912; view_y = -221459251;
    step_x = 64'd10066330; step_y = 64'd20132659; iter_lim = 64'd100;
    none     = '0;
    esc1     = '{iter_count: 16'd1, inside_res: 1'b0, red: 8'd0, green: 8'd0, blue: 8'd21};
    full100  = '{iter_count: 16'd100, inside_res: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0};
    zero_lim = '{iter_count: 16'd0, inside_res: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0};
    one_lim  = '{iter_count: 16'd1, inside_res: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0};

    add_px(0, 0, 1, esc1);
    add_px(53, 11, 1, full100);
    add_px(27, 11, 1, full100);
    add_px(1023, 1023, 0, none);
    add_px(1023, 0, 0, none);
    add_px(0, 1023, 0, none);
    add_px(40, 15, 0, none);
    add_px(45, 5, 0, none);
    add_cfg(CFG_ITER_LIM, 32'd0);
    add_px(53, 11, 1, zero_lim);
    add_px(0, 0, 1, zero_lim);
    add_cfg(CFG_ITER_LIM, 32'd1);
    add_px(0, 0, 1, one_lim);
    add_px(53, 11, 1, one_lim);
    add_cfg(CFG_X_ORIGIN, 32'h8000_0000);
    add_cfg(CFG_Y_ORIGIN, 32'h7FFF_FFFF);
    add_cfg(CFG_X_STEP, 32'hFFFF_FFFF);
    add_cfg(CFG_Y_STEP, 32'd0);
    add_cfg(CFG_ITER_LIM, 32'd65535);
    add_px(0, 0, 0, none);
    add_px(1023, 1023, 0, none);
    add_px(512, 341, 0, none);
    add_cfg(CFG_X_ORIGIN, 32'hF000_0000);
    add_cfg(CFG_Y_ORIGIN, 32'h0000_0000);
    add_cfg(CFG_X_STEP, 32'd0);
    add_cfg(CFG_Y_STEP, 32'h7FFF_FFFF);
    add_cfg(CFG_ITER_LIM, 32'd200);
    add_px(0, 0, 0, none);
    add_px(0, 1, 0, none);
    add_px(1023, 2, 0, none);
    add_px(682, 0, 0, none);

    in_idle = 14; out_idle = 73;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    sent = 0;
    while (sent < 1200) begin
      if (sent >= 800) begin
        in_idle = 0; out_idle = 0;
      end else if (sent >= 400) begin
        in_idle = 73; out_idle = 14;
      end
      drain();
      long_run = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_X_ORIGIN, $urandom);
        write_reg(CFG_Y_ORIGIN, $urandom);
        write_reg(CFG_X_STEP, $urandom);
        write_reg(CFG_Y_STEP, $urandom);
      end else begin
        write_reg(CFG_X_ORIGIN, 32'(int'($urandom_range(0, 805306368)) - 671088640));
        write_reg(CFG_Y_ORIGIN, 32'(int'($urandom_range(0, 536870912)) - 402653184));
        write_reg(CFG_X_STEP, $urandom_range(1, 3 << 20));
        write_reg(CFG_Y_STEP, $urandom_range(1, 3 << 20));
      end
      write_reg(CFG_ITER_LIM, long_run ? $urandom_range(500, 3000) : $urandom_range(1, 150));
      batch = long_run ? 8 : 50;
      repeat (batch) begin
        if ($urandom_range(0, 9) < 8) begin
          p.column = COL_W'($urandom_range(0, 127));
          p.row    = ROW_W'($urandom_range(0, 127));
        end else begin
          p = in_item_t'($urandom);
        end
        send_pixel(p, 1'b0, none);
        sent++;
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
